// ----- rtl/kwh_pkg.sv -----
// ----------------------------------------------------------------------------
// kwh_pkg: shared types and constants
// Widths, action codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package kwh_pkg;
  localparam int HIST_BINS     = 512;
  localparam int BIN_BITS      = 9;
  localparam int COORD_BITS    = 12;
  localparam int WEIGHT_BITS   = 48;
  localparam int FRACTION_BITS = 16;
  localparam int REG_BITS      = 13;
  localparam int CFG_IDX_BITS  = 2;
  localparam int DIV_CNT_BITS  = 5;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;  // unused code, ignored

  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 2'd3;

  // controller commands to the datapath
  typedef struct packed {
    logic latch;      // capture the accepted word
    logic clr_step;   // zero one memory row at clr_addr
    logic clr_total;  // zero the running total
    logic geo;        // compute window geometry stage
    logic wgt;        // compute weight stage
    logic rd;         // issue memory read at update/read address
    logic wr;         // write back saturated bin
    logic div_init;   // load divider
    logic div_step;   // one restoring step
    logic done;       // present result
  } kwh_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic div_last;
  } kwh_sts_t;
endpackage

// ----- rtl/kernel_weighted_rgb_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// kernel_weighted_rgb_histogram_unit: kernel-weighted 8x8x8 RGB histogram
// Add: geometry, weight, memory read, write back.
// Read: the 16-step serial divider forms the share, result strobed 1 cycle.
// Clear: one memory row per cycle; reset runs the same sweep.
// busy stays high during each of these; results cannot be stalled.
// ----------------------------------------------------------------------------
module kernel_weighted_rgb_histogram_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action,
  input  logic [7:0]                          blue,
  input  logic [7:0]                          green,
  input  logic [7:0]                          red,
  input  logic [kwh_pkg::COORD_BITS-1:0]      column,
  input  logic [kwh_pkg::COORD_BITS-1:0]      row,
  input  logic [kwh_pkg::BIN_BITS-1:0]        bin_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kwh_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [kwh_pkg::REG_BITS-1:0]        cfg_data,
  output logic                                result_valid,
  output logic [kwh_pkg::FRACTION_BITS:0]     bin_share,
  output logic [kwh_pkg::WEIGHT_BITS-1:0]     bin_weight,
  output logic [kwh_pkg::WEIGHT_BITS-1:0]     total_weight,
  output logic                                empty_res
);
  import kwh_pkg::*;

  kwh_cmd_t              cmd;
  kwh_sts_t              sts;
  logic [BIN_BITS-1:0]   clr_addr;
  logic [REG_BITS-1:0]   win_l, win_r, win_t, win_b;
  logic                  is_add, is_read;

  assign cfg_ready = 1'b1;

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_l <= '0;
      win_r <= '0;
      win_t <= '0;
      win_b <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEFT:   win_l <= cfg_data;
        REG_RIGHT:  win_r <= cfg_data;
        REG_TOP:    win_t <= cfg_data;
        REG_BOTTOM: win_b <= cfg_data;
        default:    win_l <= win_l;
      endcase
    end
  end

  kwh_ctrl u_ctrl (
    .clk, .rst, .start, .action, .sts, .cmd, .clr_addr, .busy
  );

  kwh_datapath u_dp (
    .clk, .rst, .cmd, .sts, .clr_addr,
    .win_l, .win_r, .win_t, .win_b,
    .action, .blue, .green, .red, .column, .row, .bin_index,
    .is_add, .is_read,
    .bin_share, .bin_weight, .total_weight, .empty_res, .result_valid
  );

  assert property (@(posedge clk) disable iff (rst) result_valid |-> busy == 1'b0)
    else $error("result shown while busy");
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && is_read) |=> busy)
    else $error("read not taken");
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && is_add) |=> !result_valid)
    else $error("add gave result");
endmodule

// ----- rtl/kwh_datapath.sv -----
// ----------------------------------------------------------------------------
// kwh_datapath: bin memory, weight arithmetic and share divider
// Holds the 512 x 48 bin memory, window math and a serial divider.
// ----------------------------------------------------------------------------
module kwh_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  kwh_pkg::kwh_cmd_t                   cmd,
  output kwh_pkg::kwh_sts_t                   sts,
  input  logic [kwh_pkg::BIN_BITS-1:0]        clr_addr,
  input  logic [kwh_pkg::REG_BITS-1:0]        win_l,
  input  logic [kwh_pkg::REG_BITS-1:0]        win_r,
  input  logic [kwh_pkg::REG_BITS-1:0]        win_t,
  input  logic [kwh_pkg::REG_BITS-1:0]        win_b,
  input  logic [1:0]                          action,
  input  logic [7:0]                          blue,
  input  logic [7:0]                          green,
  input  logic [7:0]                          red,
  input  logic [kwh_pkg::COORD_BITS-1:0]      column,
  input  logic [kwh_pkg::COORD_BITS-1:0]      row,
  input  logic [kwh_pkg::BIN_BITS-1:0]        bin_index,
  output logic                                is_add,
  output logic                                is_read,
  output logic [kwh_pkg::FRACTION_BITS:0]     bin_share,
  output logic [kwh_pkg::WEIGHT_BITS-1:0]     bin_weight,
  output logic [kwh_pkg::WEIGHT_BITS-1:0]     total_weight,
  output logic                                empty_res,
  output logic                                result_valid
);
  import kwh_pkg::*;

  localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

  logic [WEIGHT_BITS-1:0] mem [HIST_BINS];
  logic [WEIGHT_BITS-1:0] rdata;
  logic [WEIGHT_BITS-1:0] total;

  // latched word
  logic [1:0]            act_q;
  logic [BIN_BITS-1:0]   addr_q;
  logic [COORD_BITS-1:0] col_q, row_q;

  // geometry stage
  logic                  in_win;
  logic signed [14:0]    dx, dy;
  logic [11:0]           hx, hy;
  // weight stage
  logic [WEIGHT_BITS-1:0] wgt;

  // divider
  logic [WEIGHT_BITS:0]     rem;
  logic [WEIGHT_BITS-1:0]   dvs;
  logic [FRACTION_BITS-1:0] quo;
  logic [DIV_CNT_BITS-1:0]  cnt;
  logic [WEIGHT_BITS:0]     rem2;

  assign is_add  = (action == ACT_ADD);
  assign is_read = (action == ACT_READ);
  assign sts.div_last = (cnt == DIV_CNT_BITS'(FRACTION_BITS - 1));
  assign rem2 = {rem[WEIGHT_BITS-1:0], 1'b0};

  // word capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q  <= action;
      col_q  <= column;
      row_q  <= row;
      addr_q <= (action == ACT_READ) ? bin_index
              : {blue[7:5], green[7:5], red[7:5]};
    end
  end

  // window geometry: inside test, half-sizes and offsets
  always_ff @(posedge clk) begin
    logic [13:0] cx, cy;
    if (cmd.geo) begin
      cx = ({1'b0, win_r} + {1'b0, win_l}) >> 1;
      cy = ({1'b0, win_b} + {1'b0, win_t}) >> 1;
      in_win <= ({1'b0, col_q} >= win_l) && ({1'b0, col_q} < win_r)
             && ({1'b0, row_q} >= win_t) && ({1'b0, row_q} < win_b);
      hx <= 12'((win_r - win_l) >> 1);
      hy <= 12'((win_b - win_t) >> 1);
      dx <= $signed({3'b0, col_q}) - $signed({1'b0, cx});
      dy <= $signed({3'b0, row_q}) - $signed({1'b0, cy});
    end
  end

  // kernel weight bw2 - d2, zero outside
  always_ff @(posedge clk) begin
    logic [25:0] bw2, d2;
    logic [29:0] dx2, dy2;
    if (cmd.wgt) begin
      bw2 = 26'(hx) * 26'(hx) + 26'(hy) * 26'(hy);
      dx2 = $unsigned(30'(dx) * 30'(dx));
      dy2 = $unsigned(30'(dy) * 30'(dy));
      // inside the window each offset is at most 4095, so d2 fits 26 bits
      d2  = 26'(dx2 + dy2);
      wgt <= (in_win && d2 < bw2) ? WEIGHT_BITS'(bw2 - d2) : '0;
    end
  end

  // bin memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr) begin
      mem[addr_q] <= (wgt >= WMAX - rdata) ? WMAX : rdata + wgt;
    end
    if (cmd.rd) begin
      rdata <= mem[addr_q];
    end
  end

  // running total
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_total) begin
      total <= '0;
    end else if (cmd.wr) begin
      total <= (wgt >= WMAX - total) ? WMAX : total + wgt;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= {1'b0, rdata};
      dvs <= total;
      quo <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (rem2 >= {1'b0, dvs}) begin
        rem <= rem2 - {1'b0, dvs};
        quo <= {quo[FRACTION_BITS-2:0], 1'b1};
      end else begin
        rem <= rem2;
        quo <= {quo[FRACTION_BITS-2:0], 1'b0};
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.done;
    end
    if (cmd.done) begin
      bin_weight   <= rdata;
      total_weight <= dvs;
      empty_res    <= (dvs == '0);
      if (dvs == '0) begin
        bin_share <= '0;
      end else if (rdata >= dvs) begin
        bin_share <= {1'b1, {FRACTION_BITS{1'b0}}};
      end else begin
        bin_share <= {1'b0, quo};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.wr |-> !cmd.clr_step)
    else $error("write collides with clear sweep");
  assert property (@(posedge clk) disable iff (rst) $past(cmd.done) |-> result_valid)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !empty_res) |-> bin_weight <= total_weight)
    else $error("bin exceeds total");
endmodule

// ----- rtl/kwh_ctrl.sv -----
// ----------------------------------------------------------------------------
// kwh_ctrl: sequencer
// Steps each word through its datapath phases and runs the clear sweep.
// ----------------------------------------------------------------------------
module kwh_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    action,
  input  kwh_pkg::kwh_sts_t             sts,
  output kwh_pkg::kwh_cmd_t             cmd,
  output logic [kwh_pkg::BIN_BITS-1:0]  clr_addr,
  output logic                          busy
);
  import kwh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_GEO, S_WGT, S_RDA, S_WR, S_RDR, S_DINIT, S_DIV, S_DONE
  } state_t;

  state_t state;
  logic   accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.latch     = accept;
    cmd.clr_step  = (state == S_CLEAR);
    cmd.clr_total = (state == S_CLEAR);
    cmd.geo       = (state == S_GEO);
    cmd.wgt       = (state == S_WGT);
    cmd.rd        = (state == S_RDA) || (state == S_RDR);
    cmd.wr        = (state == S_WR);
    cmd.div_init  = (state == S_DINIT);
    cmd.div_step  = (state == S_DIV);
    cmd.done      = (state == S_DONE);
  end

  // state register and sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_CLEAR: begin
                state    <= S_CLEAR;
                clr_addr <= '0;
              end
              ACT_ADD:  state <= S_GEO;
              ACT_READ: state <= S_RDR;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BIN_BITS'(HIST_BINS - 1)) state <= S_IDLE;
        end
        S_GEO:   state <= S_WGT;
        S_WGT:   state <= S_RDA;
        S_RDA:   state <= S_WR;
        S_WR:    state <= S_IDLE;
        S_RDR:   state <= S_DINIT;
        S_DINIT: state <= S_DIV;
        S_DIV:   if (sts.div_last) state <= S_DONE;
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || $past(action) == ACT_NOP)
    else $error("accepted word not started");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && clr_addr == '1) |=> state == S_IDLE)
    else $error("clear sweep overran");
  assert property (@(posedge clk) disable iff (rst) $onehot0({cmd.wr, cmd.clr_step, cmd.done}))
    else $error("conflicting commands");
endmodule
